@@ src/alist_pkg.sv @@
// ----------------------------------------------------------------------------
// alist_pkg
// Shared codes, field widths and controller/datapath command types for the
// packed array list.
// ----------------------------------------------------------------------------
package alist_pkg;

	localparam int FUNC_W = 2;
	localparam int POS_W  = 5;
	localparam int DATA_W = 32;
	localparam int IDX_W  = 4;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 5;

	typedef enum logic [FUNC_W-1:0] {
		OP_APPEND = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_SEARCH = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_RANGE    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		RD_PTR    = 2'd0,
		RD_PTR_M1 = 2'd1,
		RD_PTR_P1 = 2'd2,
		RD_MID    = 2'd3
	} rd_sel_t;

	typedef enum logic {
		WD_KEY   = 1'b0,
		WD_RDATA = 1'b1
	} wd_sel_t;

	typedef enum logic {
		PTR_COUNT  = 1'b0,
		PTR_POS_M1 = 1'b1
	} ptr_sel_t;

	typedef struct packed {
		logic     load;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     wr_en;
		wd_sel_t  wd_sel;
		logic     ptr_ld;
		ptr_sel_t ptr_sel;
		logic     ptr_inc;
		logic     ptr_dec;
		logic     cnt_inc;
		logic     cnt_dec;
		logic     res_ld;
		logic     srch_init;
		logic     lo_step;
		logic     hi_step;
		logic     stat_ld;
		status_t  stat_code;
		logic     idx_ld;
		logic     out_ld;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic ins_bad;
		logic del_bad;
		logic full;
		logic ptr_at_pos;
		logic ptr_last;
		logic srch_open;
		logic key_eq;
		logic key_lt;
	} dp_stat_t;

endpackage

@@ src/alist_if.sv @@
// ----------------------------------------------------------------------------
// alist_if
// Request and response channels of the packed array list.
// ----------------------------------------------------------------------------
interface alist_req_if;
	logic                                valid;
	logic                                ready;
	logic [alist_pkg::FUNC_W-1:0]        func;
	logic [alist_pkg::POS_W-1:0]         position;
	logic signed [alist_pkg::DATA_W-1:0] value;

	modport source (output valid, func, position, value, input ready);
	modport sink (input valid, func, position, value, output ready);
endinterface

interface alist_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [alist_pkg::DATA_W-1:0] result_value;
	logic [alist_pkg::IDX_W-1:0]         result_index;
	logic [alist_pkg::STAT_W-1:0]        status;
	logic [alist_pkg::CNT_W-1:0]         fill_count;

	modport source (output valid, result_value, result_index, status, fill_count,
		input ready);
	modport sink (input valid, result_value, result_index, status, fill_count,
		output ready);
endinterface

@@ src/alist_dp.sv @@
// ----------------------------------------------------------------------------
// alist_dp
// Datapath: entry memory, fill count, move pointer, search bounds, result
// and output registers.
// ----------------------------------------------------------------------------
module alist_dp #(
	parameter int CAPACITY    = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  alist_pkg::dp_cmd_t                  cmd,
	output alist_pkg::dp_stat_t                 st,
	input  logic [alist_pkg::FUNC_W-1:0]        func,
	input  logic [alist_pkg::POS_W-1:0]         position,
	input  logic signed [alist_pkg::DATA_W-1:0] value,
	output logic signed [alist_pkg::DATA_W-1:0] result_value,
	output logic [alist_pkg::IDX_W-1:0]         result_index,
	output logic [alist_pkg::STAT_W-1:0]        status,
	output logic [alist_pkg::CNT_W-1:0]         fill_count
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > alist_pkg::POS_W) ? CW : alist_pkg::POS_W;
	localparam int XW = (VALUE_WIDTH > alist_pkg::DATA_W) ? VALUE_WIDTH : alist_pkg::DATA_W;

	logic [VALUE_WIDTH-1:0]        mem_q [CAPACITY];
	logic [VALUE_WIDTH-1:0]        rdata_q;
	logic [VALUE_WIDTH-1:0]        key_q;
	alist_pkg::op_t                op_q;
	logic [PW-1:0]                 pos_q;
	logic [IW-1:0]                 ptr_q;
	logic [CW-1:0]                 cnt_q;
	logic [CW-1:0]                 lo_q;
	logic [CW-1:0]                 hi_q;
	logic [IW-1:0]                 mid_q;
	logic [VALUE_WIDTH-1:0]        res_val_q;
	logic [IW-1:0]                 res_idx_q;
	alist_pkg::status_t            stat_q;
	logic [alist_pkg::DATA_W-1:0]  out_val_q;
	logic [alist_pkg::IDX_W-1:0]   out_idx_q;
	logic [alist_pkg::STAT_W-1:0]  out_stat_q;
	logic [alist_pkg::CNT_W-1:0]   out_cnt_q;

	logic signed [XW-1:0]          value_x;
	logic [XW-1:0]                 res_x;
	logic [VALUE_WIDTH-1:0]        key_in;
	logic [VALUE_WIDTH-1:0]        wdata;
	logic [IW-1:0]                 rd_addr;
	logic [IW-1:0]                 mid_c;
	logic [CW:0]                   mid_sum;
	logic [PW:0]                   pos_x;
	logic [PW:0]                   cnt_x;

	assign value_x = XW'(value);
	assign key_in  = value_x[VALUE_WIDTH-1:0];
	assign res_x   = XW'(res_val_q);
	assign pos_x   = {1'b0, pos_q};
	assign cnt_x   = (PW+1)'(cnt_q);
	assign mid_sum = (CW+1)'(lo_q) + (CW+1)'(hi_q) - (CW+1)'(1);
	assign mid_c   = IW'(mid_sum >> 1);
	assign wdata   = (cmd.wd_sel == alist_pkg::WD_KEY) ? key_q : rdata_q;

	always_comb begin
		unique case (cmd.rd_sel)
			alist_pkg::RD_PTR:    rd_addr = ptr_q;
			alist_pkg::RD_PTR_M1: rd_addr = ptr_q - IW'(1);
			alist_pkg::RD_PTR_P1: rd_addr = ptr_q + IW'(1);
			alist_pkg::RD_MID:    rd_addr = mid_c;
			default:              rd_addr = ptr_q;
		endcase
	end

	always_comb begin
		st.op         = op_q;
		st.ins_bad    = (pos_q == '0) || (pos_x > cnt_x + (PW+1)'(1));
		st.del_bad    = (pos_q == '0) || (pos_x > cnt_x);
		st.full       = (cnt_q == CW'(CAPACITY));
		st.ptr_at_pos = ((PW+1)'(ptr_q) + (PW+1)'(1) == pos_x);
		st.ptr_last   = (CW'(ptr_q) + CW'(1) == cnt_q);
		st.srch_open  = (lo_q < hi_q);
		st.key_eq     = (key_q == rdata_q);
		st.key_lt     = ($signed(key_q) < $signed(rdata_q));
	end

	// entry memory
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[ptr_q] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= alist_pkg::op_t'(func);
			key_q     <= key_in;
			pos_q     <= (func == alist_pkg::OP_APPEND) ? PW'(cnt_q) + PW'(1) : PW'(position);
			res_val_q <= '0;
			res_idx_q <= '0;
			stat_q    <= alist_pkg::ST_OK;
		end
		if (cmd.ptr_ld) begin
			ptr_q <= (cmd.ptr_sel == alist_pkg::PTR_COUNT) ? IW'(cnt_q) : IW'(pos_q - PW'(1));
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + IW'(1);
		end else if (cmd.ptr_dec) begin
			ptr_q <= ptr_q - IW'(1);
		end
		if (cmd.srch_init) begin
			lo_q <= '0;
			hi_q <= cnt_q;
		end else if (cmd.lo_step) begin
			lo_q <= CW'(mid_q) + CW'(1);
		end else if (cmd.hi_step) begin
			hi_q <= CW'(mid_q);
		end
		if (cmd.rd_en && cmd.rd_sel == alist_pkg::RD_MID) begin
			mid_q <= mid_c;
		end
		if (cmd.res_ld) begin
			res_val_q <= rdata_q;
		end
		if (cmd.idx_ld) begin
			res_idx_q <= mid_q;
		end
		if (cmd.stat_ld) begin
			stat_q <= cmd.stat_code;
		end
		if (cmd.out_ld) begin
			out_val_q  <= res_x[alist_pkg::DATA_W-1:0];
			out_idx_q  <= alist_pkg::IDX_W'(res_idx_q);
			out_stat_q <= stat_q;
			out_cnt_q  <= alist_pkg::CNT_W'(cnt_q);
		end
	end

	assign result_value = out_val_q;
	assign result_index = out_idx_q;
	assign status       = out_stat_q;
	assign fill_count   = out_cnt_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == $past(cnt_q) || cnt_q == CW'($past(cnt_q) + CW'(1))
		|| cnt_q == CW'($past(cnt_q) - CW'(1)))
		else $error("fill count moved by more than one");

	a_grow_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> !st.full)
		else $error("count grown on a full list");

endmodule

@@ src/alist_ctrl.sv @@
// ----------------------------------------------------------------------------
// alist_ctrl
// Controller: sequences checks, entry moves and search probes, and owns the
// channel handshakes.
// ----------------------------------------------------------------------------
module alist_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  alist_pkg::dp_stat_t st,
	output alist_pkg::dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_INS_CHK,
		S_INS_MV,
		S_DEL_RD,
		S_DEL_GET,
		S_DEL_CHK,
		S_DEL_MV,
		S_SRCH_CHK,
		S_SRCH_CMP,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = alist_pkg::dp_cmd_t'('0);
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				unique case (st.op) inside
					alist_pkg::OP_APPEND, alist_pkg::OP_INSERT: begin
						if (st.op == alist_pkg::OP_INSERT && st.ins_bad) begin
							cmd.stat_ld   = 1'b1;
							cmd.stat_code = alist_pkg::ST_RANGE;
							state_d       = S_DONE;
						end else if (st.full) begin
							cmd.stat_ld   = 1'b1;
							cmd.stat_code = alist_pkg::ST_FULL;
							state_d       = S_DONE;
						end else begin
							cmd.ptr_ld  = 1'b1;
							cmd.ptr_sel = alist_pkg::PTR_COUNT;
							state_d     = S_INS_CHK;
						end
					end
					alist_pkg::OP_DELETE: begin
						if (st.del_bad) begin
							cmd.stat_ld   = 1'b1;
							cmd.stat_code = alist_pkg::ST_RANGE;
							state_d       = S_DONE;
						end else begin
							cmd.ptr_ld  = 1'b1;
							cmd.ptr_sel = alist_pkg::PTR_POS_M1;
							state_d     = S_DEL_RD;
						end
					end
					alist_pkg::OP_SEARCH: begin
						cmd.srch_init = 1'b1;
						state_d       = S_SRCH_CHK;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_INS_CHK: begin
				if (st.ptr_at_pos) begin
					cmd.wr_en   = 1'b1;
					cmd.wd_sel  = alist_pkg::WD_KEY;
					cmd.cnt_inc = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = alist_pkg::RD_PTR_M1;
					state_d    = S_INS_MV;
				end
			end
			S_INS_MV: begin
				cmd.wr_en   = 1'b1;
				cmd.wd_sel  = alist_pkg::WD_RDATA;
				cmd.ptr_dec = 1'b1;
				state_d     = S_INS_CHK;
			end
			S_DEL_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = alist_pkg::RD_PTR;
				state_d    = S_DEL_GET;
			end
			S_DEL_GET: begin
				cmd.res_ld = 1'b1;
				state_d    = S_DEL_CHK;
			end
			S_DEL_CHK: begin
				if (st.ptr_last) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = alist_pkg::RD_PTR_P1;
					state_d    = S_DEL_MV;
				end
			end
			S_DEL_MV: begin
				cmd.wr_en   = 1'b1;
				cmd.wd_sel  = alist_pkg::WD_RDATA;
				cmd.ptr_inc = 1'b1;
				state_d     = S_DEL_CHK;
			end
			S_SRCH_CHK: begin
				if (st.srch_open) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = alist_pkg::RD_MID;
					state_d    = S_SRCH_CMP;
				end else begin
					cmd.stat_ld   = 1'b1;
					cmd.stat_code = alist_pkg::ST_NOTFOUND;
					state_d       = S_DONE;
				end
			end
			S_SRCH_CMP: begin
				if (st.key_eq) begin
					cmd.idx_ld = 1'b1;
					state_d    = S_DONE;
				end else if (st.key_lt) begin
					cmd.hi_step = 1'b1;
					state_d     = S_SRCH_CHK;
				end else begin
					cmd.lo_step = 1'b1;
					state_d     = S_SRCH_CHK;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rd_en && cmd.wr_en))
		else $error("memory read and write in one cycle");

	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == S_CHECK)
		else $error("accepted transaction not checked");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");

endmodule

@@ src/array_list_insert_delete_search.sv @@
// ----------------------------------------------------------------------------
// array_list_insert_delete_search
// Packed list of signed words with append, insert, delete and binary search.
// ----------------------------------------------------------------------------
// one transaction at a time through a single-port entry memory, so the next accept
// waits until the last is through; each entry move reads the entry, then writes it
// to its neighbouring slot; a search makes at most log2(count)+1 probes
// the next transaction is taken while a result waits
// reset clears the fill count and the handshakes; entries stay unwritten, no sweep
module array_list_insert_delete_search #(
	parameter int CAPACITY    = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	alist_req_if.sink  req,
	alist_rsp_if.source rsp
);

	alist_pkg::dp_cmd_t  cmd;
	alist_pkg::dp_stat_t st;

	alist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.st        (st),
		.cmd       (cmd)
	);

	alist_dp #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.func         (req.func),
		.position     (req.position),
		.value        (req.value),
		.result_value (rsp.result_value),
		.result_index (rsp.result_index),
		.status       (rsp.status),
		.fill_count   (rsp.fill_count)
	);

endmodule
